>>> hdl/linked_multi_stack_shared_buffer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linked stack block
// Each check is a clocked concurrent assertion, gated off during reset.
// ----------------------------------------------------------------------------
`ifndef LINKED_MULTI_STACK_SHARED_BUFFER_MACROS_SVH
`define LINKED_MULTI_STACK_SHARED_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

// plain invariant, checked every cycle out of reset
`define LMSS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("linked stack invariant violated");

// antecedent implies consequent in the next cycle
`define LMSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("linked stack sequencing violated");

`else

`define LMSS_ASSERT(lbl, cond)
`define LMSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/lmss_pkg.sv
// ----------------------------------------------------------------------------
// lmss_pkg
// Sizes, codes and word types for the linked stack block.
// ----------------------------------------------------------------------------
package lmss_pkg;

  localparam int ENTRIES    = 64;
  localparam int NUM_STACKS = 3;
  localparam int VALUE_BITS = 32;

  localparam int ADDR_BITS  = $clog2(ENTRIES);
  localparam int PTR_BITS   = $clog2(ENTRIES + 1);
  localparam int STK_BITS   = $clog2(NUM_STACKS);
  localparam int ENTRY_BITS = VALUE_BITS + PTR_BITS;

  typedef logic [PTR_BITS-1:0] ptr_t;

  // null marker: one past the last entry
  localparam ptr_t NULL_PTR = ptr_t'(ENTRIES);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         stack_id;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic               is_empty;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    ptr_t                  link;
  } entry_t;

endpackage

>>> hdl/lmss_ram.sv
// ----------------------------------------------------------------------------
// lmss_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module lmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/linked_multi_stack_shared_buffer.sv
// ----------------------------------------------------------------------------
// linked_multi_stack_shared_buffer
// Several stacks threaded through one entry RAM by per-entry links.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (cmd, stack_id, value) arrive on in_valid/in_stall; each one
//   gives exactly one output word (top_value, is_empty, status) on
//   out_valid/out_stall. A word moves when valid is high and stall is low.
//   Push takes the next never-used entry; pop follows the top entry's link.
//   Popped entries are not reused. Read (and code 3) just returns the top.
//   A push with room, a refused pop, a bad stack id, and a read or refused
//   push of an empty stack are answered straight from the idle state. Else
//   the entry RAM's registered read is used: a read or refused push reads
//   the top's value (ST_VAL); a pop reads the top's link (ST_LINK) and, if
//   the stack is not left empty, then the new top's value (ST_VAL).
//   The next word is taken once the block is back in idle and the output is
//   free, so pushes run at one word a cycle while out_stall is low; a read
//   or pop that uses the RAM holds off the next word until its result is out.
//   A registered output word parts the two sides; while out_stall holds it,
//   no new word is taken: in_stall stays high until the output is free.
//   Reset (rst_n low, synchronous) empties every stack and rewinds the
//   allocator; RAM contents are left as they are and need no clearing.
// ----------------------------------------------------------------------------
`include "linked_multi_stack_shared_buffer_macros.svh"

module linked_multi_stack_shared_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lmss_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output lmss_pkg::out_word_t out_word
);
  import lmss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_VAL
  } state_t;

  state_t               state_r, state_nxt;
  ptr_t                 top_r [NUM_STACKS];
  ptr_t                 top_nxt [NUM_STACKS];
  ptr_t                 next_free_r, next_free_nxt;
  logic [STK_BITS-1:0]  sid_r, sid_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_r, out_nxt;

  logic                 out_free;
  logic                 in_acc;
  logic [STK_BITS-1:0]  in_sid;
  logic                 sid_ok;
  ptr_t                 cur_top;
  logic                 cur_null;
  logic                 full;
  logic [VALUE_BITS-1:0] push_val;

  logic                 wr_en;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [ENTRY_BITS-1:0] rd_raw;
  entry_t               rd_ent;
  entry_t               wr_ent;

  lmss_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (next_free_r[ADDR_BITS-1:0]),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_ent = entry_t'(rd_raw);

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign in_sid   = STK_BITS'(in_word.stack_id);
  assign sid_ok   = 32'(in_word.stack_id) < NUM_STACKS;
  assign cur_top  = sid_ok ? top_r[in_sid] : NULL_PTR;
  assign cur_null = (cur_top == NULL_PTR);
  assign full     = (next_free_r == NULL_PTR);
  assign push_val = VALUE_BITS'($unsigned(in_word.value));
  assign wr_ent   = '{val: push_val, link: cur_top};

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    next_free_nxt = next_free_r;
    sid_nxt       = sid_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cur_top[ADDR_BITS-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sid_nxt    = in_sid;
          status_nxt = STAT_OK;
          if (!sid_ok) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{top_value: '0, is_empty: 1'b1, status: STAT_OK};
          end else if (in_word.cmd == CMD_PUSH && !full) begin
            wr_en           = 1'b1;
            top_nxt[in_sid] = next_free_r;
            next_free_nxt   = next_free_r + ptr_t'(1);
            out_valid_nxt   = 1'b1;
            out_nxt         = '{top_value: $signed(32'(push_val)), is_empty: 1'b0,
                                status: STAT_OK};
          end else if (in_word.cmd == CMD_POP) begin
            if (cur_null) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{top_value: '0, is_empty: 1'b1, status: STAT_EMPTY};
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_LINK;
            end
          end else begin
            // read top (and code 3), also a refused push
            status_nxt = (in_word.cmd == CMD_PUSH) ? STAT_FULL : STAT_OK;
            if (cur_null) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{top_value: '0, is_empty: 1'b1, status: status_nxt};
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_VAL;
            end
          end
        end
      end
      ST_LINK: begin
        if (rd_ent.link == NULL_PTR) begin
          if (out_free) begin
            top_nxt[sid_r] = NULL_PTR;
            out_valid_nxt  = 1'b1;
            out_nxt        = '{top_value: '0, is_empty: 1'b1, status: status_r};
            state_nxt      = ST_IDLE;
          end
        end else begin
          top_nxt[sid_r] = rd_ent.link;
          rd_en          = 1'b1;
          rd_addr        = rd_ent.link[ADDR_BITS-1:0];
          state_nxt      = ST_VAL;
        end
      end
      ST_VAL: begin
        // read data holds while the output is blocked
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{top_value: $signed(32'(rd_ent.val)), is_empty: 1'b0,
                            status: status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sid_r    <= sid_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= NULL_PTR;
      end
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `LMSS_ASSERT(a_alloc_bound, next_free_r <= NULL_PTR)

  `LMSS_ASSERT(a_no_rw_clash, !(wr_en && rd_en))

  `LMSS_ASSERT_NEXT(a_push_one_cycle, in_acc && sid_ok && in_word.cmd == CMD_PUSH && !full,
                    out_valid_r && state_r == ST_IDLE)

  for (genvar g = 0; g < NUM_STACKS; g++) begin : g_top_chk
    `LMSS_ASSERT(a_top_allocated, (top_r[g] == NULL_PTR) || (top_r[g] < next_free_r))
  end

endmodule

>>> verif/linked_multi_stack_shared_buffer_test.sv
// ----------------------------------------------------------------------------
// linked_multi_stack_shared_buffer_test
// Self-checking bench for the shared-memory linked stacks. A short table of
// directed words walks the edge cases, then random words follow in three
// phases of sender and receiver idling. A model of the stacks predicts each
// result the table does not give; all are checked in order, field by field.
// ----------------------------------------------------------------------------
module linked_multi_stack_shared_buffer_test;
  import lmss_pkg::*;

  localparam logic [1:0]  CMD_SPARE = 2'd3;   // unused code, acts as read
  localparam logic [1:0]  STACK_BAD = 2'd3;   // no such stack
  localparam logic [31:0] MAX_VAL   = 32'h7fff_ffff;
  localparam logic [31:0] MIN_VAL   = 32'h8000_0000;
  localparam int          WATCHDOG  = 2000;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t res;
  } plan_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  // stack model state
  entry_t      mem_model [ENTRIES];
  ptr_t        top_model [NUM_STACKS];
  int unsigned alloc_next;

  out_word_t pending_q [$];
  out_word_t oldest;
  plan_row_t plan [$];

  int send_gap_pct;
  int stall_pct;
  int errors;
  int idle_cycles;
  int n_push, n_pop, n_read, n_full, n_empty, n_bad;

  linked_multi_stack_shared_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_word_t stack_step(input in_word_t w);
    out_word_t r;
    int        s;
    r.top_value = '0;
    r.is_empty  = 1'b1;
    r.status    = STAT_OK;
    if (int'(w.stack_id) < NUM_STACKS) begin
      s = int'(w.stack_id);
      case (w.cmd)
        CMD_PUSH: begin
          if (alloc_next >= ENTRIES) begin
            r.status = STAT_FULL;
          end else begin
            mem_model[alloc_next].val  = w.value;
            mem_model[alloc_next].link = top_model[s];
            top_model[s] = ptr_t'(alloc_next);
            alloc_next++;
          end
        end
        CMD_POP: begin
          if (top_model[s] == NULL_PTR) r.status = STAT_EMPTY;
          else top_model[s] = mem_model[top_model[s]].link;
        end
        default: ;
      endcase
      if (top_model[s] != NULL_PTR) begin
        r.top_value = mem_model[top_model[s]].val;
        r.is_empty  = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic plan_row_t mk_row(input logic [1:0] c, input logic [1:0] sid,
                                       input logic [31:0] v, input bit t,
                                       input logic [31:0] tv, input logic e,
                                       input logic [1:0] st);
    plan_row_t p;
    p.word.cmd      = c;
    p.word.stack_id = sid;
    p.word.value    = v;
    p.typed         = t;
    p.res.top_value = tv;
    p.res.is_empty  = e;
    p.res.status    = st;
    return p;
  endfunction

  // drive one word, hold it until taken, then record its expected result
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = stack_step(w);
    pending_q.push_back(typed ? typed_res : want);
    if (int'(w.stack_id) >= NUM_STACKS) n_bad++;
    else if (want.status == STAT_FULL) n_full++;
    else if (want.status == STAT_EMPTY) n_empty++;
    else if (w.cmd == CMD_PUSH) n_push++;
    else if (w.cmd == CMD_POP) n_pop++;
    else n_read++;
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, got %h",
                 $time, out_word);
        errors++;
      end else begin
        oldest = pending_q.pop_front();
        check_field("top_value", oldest.top_value, out_word.top_value);
        check_field("is_empty", 32'(oldest.is_empty), 32'(out_word.is_empty));
        check_field("status", 32'(oldest.status), 32'(out_word.status));
      end
    end
  end

  // counts cycles in which no word moves on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG, pending_q.size());
      $display("FAIL linked_multi_stack_shared_buffer");
      $finish;
    end
  end

  initial begin : stimulus
    in_word_t rnd;
    int       pick;
    int       ph;
    int       k;
    in_valid     = 1'b0;
    in_word      = '0;
    out_stall    = 1'b0;
    rst_n        = 1'b0;
    send_gap_pct = 14;
    stall_pct    = 51;
    errors       = 0;
    idle_cycles  = 0;
    n_push = 0; n_pop = 0; n_read = 0; n_full = 0; n_empty = 0; n_bad = 0;
    alloc_next   = 0;
    for (k = 0; k < NUM_STACKS; k++) top_model[k] = NULL_PTR;

    // cmd, stack, value, typed, top_value, is_empty, status
    plan.push_back(mk_row(CMD_READ,  2'd0, 32'd0,        1, 32'd0,   1, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd1, 32'd0,        1, 32'd0,   1, STAT_EMPTY));
    plan.push_back(mk_row(CMD_SPARE, 2'd2, 32'hffff_ffff, 1, 32'd0,  1, STAT_OK));
    plan.push_back(mk_row(CMD_PUSH,  2'd0, MAX_VAL,      1, MAX_VAL, 0, STAT_OK));
    plan.push_back(mk_row(CMD_PUSH,  2'd1, MIN_VAL,      1, MIN_VAL, 0, STAT_OK));
    plan.push_back(mk_row(CMD_PUSH,  2'd2, 32'd0,        1, 32'd0,   0, STAT_OK));
    plan.push_back(mk_row(CMD_PUSH,  2'd0, 32'hffff_ffff, 1, 32'hffff_ffff, 0, STAT_OK));
    // bad stack number: ignored, no entry taken
    plan.push_back(mk_row(CMD_PUSH,  STACK_BAD, 32'd5,   1, 32'd0,   1, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   STACK_BAD, 32'd0,   1, 32'd0,   1, STAT_OK));
    plan.push_back(mk_row(CMD_READ,  STACK_BAD, 32'd0,   1, 32'd0,   1, STAT_OK));
    plan.push_back(mk_row(CMD_SPARE, 2'd0, 32'd0,        0, 32'd0,   0, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd0, 32'd0,        1, MAX_VAL, 0, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd0, 32'd0,        1, 32'd0,   1, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd0, 32'd0,        1, 32'd0,   1, STAT_EMPTY));
    plan.push_back(mk_row(CMD_PUSH,  2'd1, 32'h5a5a_5a5a, 0, 32'd0,  0, STAT_OK));
    plan.push_back(mk_row(CMD_READ,  2'd1, 32'd0,        0, 32'd0,   0, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd1, 32'd0,        0, 32'd0,   0, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd1, 32'd0,        1, 32'd0,   1, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd1, 32'd0,        1, 32'd0,   1, STAT_EMPTY));
    plan.push_back(mk_row(CMD_PUSH,  2'd2, 32'd1,        0, 32'd0,   0, STAT_OK));
    plan.push_back(mk_row(CMD_POP,   2'd2, 32'd0,        0, 32'd0,   0, STAT_OK));
    plan.push_back(mk_row(CMD_READ,  2'd2, 32'd0,        0, 32'd0,   0, STAT_OK));
    plan.push_back(mk_row(CMD_PUSH,  2'd0, 32'h1234_5678, 0, 32'd0,  0, STAT_OK));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_gap_pct = 14; stall_pct = 51; end
        1: begin send_gap_pct = 51; stall_pct = 14; end
        default: begin send_gap_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 0) begin
        foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].res);
      end
      // popped entries are never reused, so memory fills part way through
      for (k = 0; k < 168; k++) begin
        pick = $urandom_range(99);
        if (pick < 30) rnd.cmd = CMD_PUSH;
        else if (pick < 62) rnd.cmd = CMD_POP;
        else if (pick < 88) rnd.cmd = CMD_READ;
        else rnd.cmd = CMD_SPARE;
        if ($urandom_range(99) < 6) rnd.stack_id = STACK_BAD;
        else rnd.stack_id = 2'($urandom_range(NUM_STACKS - 1));
        rnd.value = $urandom;
        send_word(rnd, 1'b0, '0);
      end
      // hold off until the block has drained
      in_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
      @(posedge clk);
    end

    repeat (8) @(posedge clk);
    $display("covered %0d pushes, %0d pops, %0d reads, %0d full and %0d empty refusals,",
             n_push, n_pop, n_read, n_full, n_empty);
    $display("%0d words to a missing stack, over three idling phases", n_bad);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS linked_multi_stack_shared_buffer");
    end else begin
      $display("FAIL linked_multi_stack_shared_buffer");
    end
    $finish;
  end

endmodule
